>>> hdl/sirm_pkg.sv
// Shared constants, result codes and controller/datapath interface types.
package sirm_pkg;

    localparam int unsigned CAPACITY = 1024;
    localparam int unsigned ADDR_W   = $clog2(CAPACITY);
    localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);
    localparam int unsigned POS_W    = 11;
    localparam int unsigned DATA_W   = 32;

    localparam logic [CNT_W-1:0] COUNT_FULL = CNT_W'(CAPACITY);
    localparam logic signed [DATA_W-1:0] MIN_INIT = {1'b0, {(DATA_W-1){1'b1}}};

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_QUERY  = 1'b1;

    localparam logic [1:0] STATUS_INSERTED  = 2'd0;
    localparam logic [1:0] STATUS_ANSWERED  = 2'd1;
    localparam logic [1:0] STATUS_FULL      = 2'd2;
    localparam logic [1:0] STATUS_BAD_RANGE = 2'd3;

    typedef struct packed {
        logic       load;
        logic       rd_prev;
        logic       rd_cur;
        logic       wr_shift;
        logic       wr_put;
        logic       acc;
        logic       finish;
        logic [1:0] result_status;
    } cmd_t;

    typedef struct packed {
        logic is_query;
        logic full;
        logic bad_range;
        logic at_pos;
        logic at_last;
    } stat_t;

endpackage

>>> hdl/sirm_ctrl.sv
// Sequencing state machine for insert shifting and range scanning.
module sirm_ctrl
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  sirm_pkg::stat_t stat,
    output sirm_pkg::cmd_t  cmd,
    output logic            busy
);
    import sirm_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE     = 7'b0000001,
        S_CHECK    = 7'b0000010,
        S_SHIFT_RD = 7'b0000100,
        S_SHIFT_WR = 7'b0001000,
        S_PUT      = 7'b0010000,
        S_Q_RD     = 7'b0100000,
        S_Q_ACC    = 7'b1000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (stat.is_query)
                begin
                    if (stat.bad_range)
                    begin
                        cmd.finish        = 1'b1;
                        cmd.result_status = STATUS_BAD_RANGE;
                        state_next        = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_Q_RD;
                    end
                end
                else if (stat.full)
                begin
                    cmd.finish        = 1'b1;
                    cmd.result_status = STATUS_FULL;
                    state_next        = S_IDLE;
                end
                else if (stat.at_pos)
                begin
                    state_next = S_PUT;
                end
                else
                begin
                    state_next = S_SHIFT_RD;
                end
            end
            S_SHIFT_RD:
            begin
                cmd.rd_prev = 1'b1;
                state_next  = S_SHIFT_WR;
            end
            S_SHIFT_WR:
            begin
                cmd.wr_shift = 1'b1;
                // The pointer steps down this cycle; compare against the decremented one.
                state_next   = S_SHIFT_RD;
                if (stat.at_pos)
                begin
                    state_next = S_PUT;
                end
            end
            S_PUT:
            begin
                cmd.wr_put        = 1'b1;
                cmd.finish        = 1'b1;
                cmd.result_status = STATUS_INSERTED;
                state_next        = S_IDLE;
            end
            S_Q_RD:
            begin
                cmd.rd_cur = 1'b1;
                state_next = S_Q_ACC;
            end
            S_Q_ACC:
            begin
                cmd.acc = 1'b1;
                if (stat.at_last)
                begin
                    cmd.finish        = 1'b1;
                    cmd.result_status = STATUS_ANSWERED;
                    state_next        = S_IDLE;
                end
                else
                begin
                    state_next = S_Q_RD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);

endmodule

>>> hdl/sirm_datapath.sv
// Element memory, count, scan pointer, minimum accumulator and result registers.
module sirm_datapath
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  sirm_pkg::cmd_t                       cmd,
    output sirm_pkg::stat_t                      stat,
    input  logic                                 opcode,
    input  logic [sirm_pkg::POS_W-1:0]           ins_position,
    input  logic signed [sirm_pkg::DATA_W-1:0]   ins_value,
    input  logic [sirm_pkg::POS_W-1:0]           range_first,
    input  logic [sirm_pkg::POS_W-1:0]           range_last,
    output logic                                 done,
    output logic signed [sirm_pkg::DATA_W-1:0]   min_value,
    output logic [1:0]                           status
);
    import sirm_pkg::*;

    logic signed [DATA_W-1:0] mem [CAPACITY];

    logic                     op_reg;
    logic [CNT_W-1:0]         pos_reg;
    logic [CNT_W-1:0]         pos_next;
    logic signed [DATA_W-1:0] value_reg;
    logic [POS_W-1:0]         first_reg;
    logic [POS_W-1:0]         last_reg;
    logic [CNT_W-1:0]         count_reg;
    logic [CNT_W-1:0]         count_next;
    logic [CNT_W-1:0]         ptr_reg;
    logic [CNT_W-1:0]         ptr_next;
    logic [CNT_W-1:0]         ptr_dec;
    logic [POS_W-1:0]         last_dec;
    logic signed [DATA_W-1:0] rdata_reg;
    logic signed [DATA_W-1:0] min_reg;
    logic signed [DATA_W-1:0] min_next;
    logic                     done_reg;
    logic signed [DATA_W-1:0] result_min_reg;
    logic [1:0]               status_reg;
    logic [ADDR_W-1:0]        rd_addr;
    logic [ADDR_W-1:0]        wr_addr;
    logic signed [DATA_W-1:0] wr_data;

    assign ptr_dec  = ptr_reg - CNT_W'(1);
    assign last_dec = last_reg - POS_W'(1);

    // Positions past the end append.
    always_comb
    begin
        pos_next = CNT_W'(ins_position);
        if (CNT_W'(ins_position) > count_reg)
        begin
            pos_next = count_reg;
        end
    end

    always_comb
    begin
        ptr_next = ptr_reg;
        if (cmd.load)
        begin
            ptr_next = (opcode == OP_QUERY) ? CNT_W'(range_first - POS_W'(1)) : count_reg;
        end
        else if (cmd.wr_shift)
        begin
            ptr_next = ptr_dec;
        end
        else if (cmd.acc)
        begin
            ptr_next = ptr_reg + CNT_W'(1);
        end
    end

    always_comb
    begin
        min_next = min_reg;
        if (cmd.load)
        begin
            min_next = MIN_INIT;
        end
        else if (cmd.acc && (rdata_reg < min_reg))
        begin
            min_next = rdata_reg;
        end
    end

    assign count_next = cmd.wr_put ? count_reg + CNT_W'(1) : count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            done_reg  <= cmd.finish;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg    <= opcode;
            pos_reg   <= pos_next;
            value_reg <= ins_value;
            first_reg <= range_first;
            last_reg  <= range_last;
        end
        ptr_reg <= ptr_next;
        min_reg <= min_next;
        if (cmd.finish)
        begin
            status_reg     <= cmd.result_status;
            result_min_reg <= (cmd.result_status == STATUS_ANSWERED) ? min_next : '0;
        end
    end

    assign rd_addr = cmd.rd_prev ? ptr_dec[ADDR_W-1:0] : ptr_reg[ADDR_W-1:0];
    assign wr_addr = cmd.wr_put ? pos_reg[ADDR_W-1:0] : ptr_reg[ADDR_W-1:0];
    assign wr_data = cmd.wr_put ? value_reg : rdata_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.rd_prev || cmd.rd_cur)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.wr_shift || cmd.wr_put)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    assign stat.is_query  = (op_reg == OP_QUERY);
    assign stat.full      = (count_reg == COUNT_FULL);
    assign stat.bad_range = (first_reg == '0) || (first_reg > last_reg)
                            || (CNT_W'(last_reg) > count_reg);
    assign stat.at_pos    = cmd.wr_shift ? (ptr_dec == pos_reg) : (ptr_reg == pos_reg);
    assign stat.at_last   = (ptr_reg == CNT_W'(last_dec));

    assign done      = done_reg;
    assign min_value = result_min_reg;
    assign status    = status_reg;

endmodule

>>> hdl/sequence_insert_range_min.sv
// Top level: ordered sequence store with positional insert and range minimum.
// Each request ends with the done strobe: a refused insert or a bad range ends
// after the check, an insert after shifting each element from the end down to
// its position, and a query after scanning each element from first to last.
// Each moved or scanned element takes a registered memory read, then a write or
// compare. One request is in work at a time; busy is high until it finishes.
// The done strobe lasts one cycle and cannot be stalled by the receiver.
// Reset (rst_n low, asynchronous) empties the sequence and returns to idle.
module sequence_insert_range_min
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic                                 opcode,
    input  logic [sirm_pkg::POS_W-1:0]           ins_position,
    input  logic signed [sirm_pkg::DATA_W-1:0]   ins_value,
    input  logic [sirm_pkg::POS_W-1:0]           range_first,
    input  logic [sirm_pkg::POS_W-1:0]           range_last,
    output logic                                 done,
    output logic signed [sirm_pkg::DATA_W-1:0]   min_value,
    output logic [1:0]                           status
);
    import sirm_pkg::*;

    // Commands flow from the controller to the datapath; status flows back.
    cmd_t  cmd;
    stat_t stat;

    // The controller walks the request through check, shift or scan, and finish.
    sirm_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    // The datapath captures the request at acceptance, holds the element memory
    // and the count, and registers the result shown with the done strobe.
    sirm_datapath u_datapath
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .opcode       (opcode),
        .ins_position (ins_position),
        .ins_value    (ins_value),
        .range_first  (range_first),
        .range_last   (range_last),
        .done         (done),
        .min_value    (min_value),
        .status       (status)
    );

endmodule

>>> tb/sirm_checker.sv
// Checker that predicts and compares every result of the sequence store with range minimum.
`timescale 1ns / 100ps

module sirm_checker
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    input  logic                                 busy,
    input  logic                                 opcode,
    input  logic [sirm_pkg::POS_W-1:0]           ins_position,
    input  logic signed [sirm_pkg::DATA_W-1:0]   ins_value,
    input  logic [sirm_pkg::POS_W-1:0]           range_first,
    input  logic [sirm_pkg::POS_W-1:0]           range_last,
    input  logic                                 done,
    input  logic signed [sirm_pkg::DATA_W-1:0]   min_value,
    input  logic [1:0]                           status,
    output int                                   error_count,
    output int                                   waiting_count,
    output int                                   inserted_count,
    output int                                   refused_count,
    output int                                   answered_count,
    output int                                   bad_range_count
);

    import sirm_pkg::*;

    typedef struct packed {
        logic signed [DATA_W-1:0] min_value;
        logic [1:0]               status;
    } seq_result_t;

    // Shadow copy of the ordered sequence; only the first seq_len entries are meaningful.
    logic signed [DATA_W-1:0] seq_vals [CAPACITY];
    int unsigned              seq_len;
    seq_result_t              expected_results [$];
    int                       result_index;

    initial
    begin
        seq_len         = 0;
        result_index    = 0;
        error_count     = 0;
        waiting_count   = 0;
        inserted_count  = 0;
        refused_count   = 0;
        answered_count  = 0;
        bad_range_count = 0;
    end

    // Applies one request to the shadow sequence and returns the result it must produce.
    function automatic seq_result_t apply_request(
        input logic                      op,
        input logic [POS_W-1:0]          pos,
        input logic signed [DATA_W-1:0]  val,
        input logic [POS_W-1:0]          first,
        input logic [POS_W-1:0]          last
    );
        seq_result_t              res;
        int unsigned              at;
        logic signed [DATA_W-1:0] lowest;
        res.min_value = '0;
        if (op == OP_INSERT)
        begin
            if (seq_len >= CAPACITY)
            begin
                res.status = STATUS_FULL;
            end
            else
            begin
                at = (pos > seq_len) ? seq_len : pos;
                for (int k = seq_len; k > at; k--)
                    seq_vals[k] = seq_vals[k-1];
                seq_vals[at] = val;
                seq_len++;
                res.status = STATUS_INSERTED;
            end
        end
        else if (first == 0 || first > last || last > seq_len)
        begin
            res.status = STATUS_BAD_RANGE;
        end
        else
        begin
            lowest = seq_vals[first-1];
            for (int k = first; k < last; k++)
                if (seq_vals[k] < lowest)
                    lowest = seq_vals[k];
            res.min_value = lowest;
            res.status    = STATUS_ANSWERED;
        end
        return res;
    endfunction

    always @(posedge clk)
    begin
        seq_result_t want;
        seq_result_t pred;
        if (rst_n)
        begin
            // The strobe is handled before a new request, as it belongs to the older one.
            if (done)
            begin
                if (expected_results.size() == 0)
                begin
                    if (error_count < 10)
                        $display("sirm_checker: unexpected result status %0d min_value %0d",
                                 status, min_value);
                    error_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (status !== want.status || min_value !== want.min_value)
                    begin
                        if (error_count < 10)
                            $display("sirm_checker: result %0d mismatch: status exp %0d got %0d,",
                                     result_index, want.status, status,
                                     " min_value exp %0d got %0d", want.min_value, min_value);
                        error_count++;
                    end
                end
                result_index++;
            end
            if (start && !busy)
            begin
                pred = apply_request(opcode, ins_position, ins_value, range_first, range_last);
                case (pred.status)
                    STATUS_INSERTED: inserted_count++;
                    STATUS_FULL:     refused_count++;
                    STATUS_ANSWERED: answered_count++;
                    default:         bad_range_count++;
                endcase
                expected_results.push_back(pred);
            end
            waiting_count = expected_results.size();
        end
    end

endmodule

>>> tb/tb_sequence_insert_range_min.sv
// Top of the testbench: clock, reset, request stimulus and the final verdict.
`timescale 1ns / 100ps

module tb_sequence_insert_range_min;

    import sirm_pkg::*;

    // Generous ceiling on the run.
    localparam int LIMIT_CYCLES = 16_000_000;
    localparam int POS_MAX      = (1 << POS_W) - 1;

    logic                      clk          = 1'b0;
    logic                      rst_n        = 1'b0;
    logic                      start        = 1'b0;
    logic                      opcode       = OP_INSERT;
    logic [POS_W-1:0]          ins_position = '0;
    logic signed [DATA_W-1:0]  ins_value    = '0;
    logic [POS_W-1:0]          range_first  = '0;
    logic [POS_W-1:0]          range_last   = '0;
    logic                      busy;
    logic                      done;
    logic signed [DATA_W-1:0]  min_value;
    logic [1:0]                status;

    int error_count;
    int waiting_count;
    int inserted_count;
    int refused_count;
    int answered_count;
    int bad_range_count;

    // Stimulus-side bookkeeping only: how many elements the store should hold,
    // used to aim positions and spans at the interesting places.
    int unsigned fill_level = 0;
    int          requests_sent = 0;
    int          cycle_count = 0;

    sequence_insert_range_min dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .opcode       (opcode),
        .ins_position (ins_position),
        .ins_value    (ins_value),
        .range_first  (range_first),
        .range_last   (range_last),
        .done         (done),
        .min_value    (min_value),
        .status       (status)
    );

    sirm_checker u_checker
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .opcode          (opcode),
        .ins_position    (ins_position),
        .ins_value       (ins_value),
        .range_first     (range_first),
        .range_last      (range_last),
        .done            (done),
        .min_value       (min_value),
        .status          (status),
        .error_count     (error_count),
        .waiting_count   (waiting_count),
        .inserted_count  (inserted_count),
        .refused_count   (refused_count),
        .answered_count  (answered_count),
        .bad_range_count (bad_range_count)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Idle time between requests. Every fourth stretch of 50 requests runs
    // back to back; otherwise gaps are mostly short with an occasional long one,
    // so that a new request lands on every phase of a shift or a scan.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if ((requests_sent / 50) % 4 == 0)
            return 0;
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(30, 80);
    endfunction

    // Presents one request and holds it until the block takes it, then idles.
    // A request is taken at a rising edge where start is high and busy is low;
    // busy is read right after the edge, before the block's own updates land.
    task automatic send_request(
        input logic                      op,
        input logic [POS_W-1:0]          pos,
        input logic signed [DATA_W-1:0]  val,
        input logic [POS_W-1:0]          first,
        input logic [POS_W-1:0]          last
    );
        int gap;
        opcode       <= op;
        ins_position <= pos;
        ins_value    <= val;
        range_first  <= first;
        range_last   <= last;
        start        <= 1'b1;
        do
            @(posedge clk);
        while (busy);
        if (op == OP_INSERT && fill_level < CAPACITY)
            fill_level++;
        requests_sent++;
        // Start stays high when the next request follows at once, so it gets
        // only one assignment in this time step either way.
        gap = pick_gap();
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // One random request. Fields that the operation ignores still carry random
    // bits. Inserts mostly land near the end of the sequence, where shifting is
    // cheap, and now and then at the front or anywhere. Queries mostly cover a
    // short span, sometimes a long one or the whole sequence, and a quarter are
    // malformed in one of the three ways the block must flag.
    task automatic random_request(input int insert_pct);
        logic                      op;
        logic [POS_W-1:0]          pos;
        logic [POS_W-1:0]          first;
        logic [POS_W-1:0]          last;
        logic signed [DATA_W-1:0]  val;
        int                        r;
        int unsigned               lvl;
        int unsigned               lo;
        int unsigned               hi;
        lvl   = fill_level;
        pos   = POS_W'($urandom);
        first = POS_W'($urandom);
        last  = POS_W'($urandom);
        val   = $urandom;
        op    = ($urandom_range(0, 99) < insert_pct) ? OP_INSERT : OP_QUERY;
        r     = $urandom_range(0, 99);
        if (op == OP_INSERT)
        begin
            if (r < 60)
                pos = POS_W'(lvl - $urandom_range(0, (lvl < 6) ? lvl : 6));
            else if (r < 75)
                pos = POS_W'($urandom_range(lvl, POS_MAX));
            else if (r < 80)
                pos = '0;
            else
                pos = POS_W'($urandom_range(0, lvl));
            r = $urandom_range(0, 99);
            if (r < 10)
            begin
                case ($urandom_range(0, 3))
                    0:       val = {1'b1, {(DATA_W-1){1'b0}}};
                    1:       val = {1'b0, {(DATA_W-1){1'b1}}};
                    2:       val = '0;
                    default: val = '1;
                endcase
            end
            else if (r < 25)
            begin
                // Small values make ties for the minimum common.
                val = $signed($urandom_range(0, 20)) - 10;
            end
        end
        else if (lvl > 0 && r < 75)
        begin
            if (r < 60)
            begin
                lo = $urandom_range(1, lvl);
                hi = lo + $urandom_range(0, 15);
                if (hi > lvl)
                    hi = lvl;
            end
            else if (r < 70)
            begin
                lo = $urandom_range(1, lvl);
                hi = $urandom_range(lo, lvl);
            end
            else
            begin
                lo = 1;
                hi = lvl;
            end
            first = POS_W'(lo);
            last  = POS_W'(hi);
        end
        else
        begin
            case ($urandom_range(0, 2))
                0:
                begin
                    // A first position of zero.
                    first = '0;
                    last  = POS_W'($urandom_range(0, POS_MAX));
                end
                1:
                begin
                    // A span that runs backward.
                    lo    = $urandom_range(2, POS_MAX);
                    first = POS_W'(lo);
                    last  = POS_W'($urandom_range(1, lo - 1));
                end
                default:
                begin
                    // A span that ends past the last element.
                    hi    = $urandom_range(lvl + 1, POS_MAX);
                    last  = POS_W'(hi);
                    first = POS_W'($urandom_range(1, hi));
                end
            endcase
        end
        send_request(op, pos, val, first, last);
    endtask

    // The cycle counter ends a run that hangs.
    initial
    begin
        while (cycle_count < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("tb_sequence_insert_range_min: errors");
        $finish;
    end

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part. A query on the empty store must be flagged, then the
        // sequence is built from the extreme values through inserts at the front,
        // in the middle and past the end, including positions with the top bit set.
        send_request(OP_QUERY, 11'd0, '0, 11'd1, 11'd1);
        send_request(OP_INSERT, 11'd0, 32'sh7FFF_FFFF, 11'd0, 11'd0);
        send_request(OP_INSERT, 11'd2047, 32'sh8000_0000, 11'd2047, 11'd2047);
        send_request(OP_INSERT, 11'd1, -32'sd1, 11'd5, 11'd3);
        send_request(OP_INSERT, 11'd0, 32'sd0, 11'd1024, 11'd1024);
        send_request(OP_INSERT, 11'd1024, 32'sd5, 11'd0, 11'd0);
        // Sequence is now 0, max, -1, min, 5: spans over all of it, single
        // elements at both ends, and a span that holds the most negative value.
        send_request(OP_QUERY, 11'd0, 32'sh5555_5555, 11'd1, 11'd5);
        send_request(OP_QUERY, 11'd0, '0, 11'd1, 11'd1);
        send_request(OP_QUERY, 11'd0, '0, 11'd5, 11'd5);
        send_request(OP_QUERY, 11'd0, '0, 11'd2, 11'd2);
        send_request(OP_QUERY, 11'd0, '0, 11'd3, 11'd4);
        send_request(OP_QUERY, 11'd0, '0, 11'd1, 11'd3);
        // The three kinds of bad span.
        send_request(OP_QUERY, 11'd0, '0, 11'd0, 11'd3);
        send_request(OP_QUERY, 11'd0, '0, 11'd4, 11'd3);
        send_request(OP_QUERY, 11'd0, '0, 11'd1, 11'd6);
        send_request(OP_QUERY, 11'd0, '0, 11'd1024, 11'd1024);
        send_request(OP_QUERY, 11'd2047, '1, 11'd2047, 11'd2047);
        // Alternating bit patterns inserted in the middle, then checked.
        send_request(OP_INSERT, 11'd3, 32'sh5555_5555, 11'd0, 11'd0);
        send_request(OP_INSERT, 11'd2, 32'shAAAA_AAAA, 11'h555, 11'h2AA);
        send_request(OP_QUERY, 11'h2AA, '0, 11'd2, 11'd7);
        send_request(OP_QUERY, 11'd0, '0, 11'd5, 11'd7);

        // Random part: a balanced mix while the store is small, then mostly
        // inserts until it is full, then refused inserts and queries on the
        // full store.
        repeat (300) random_request(50);
        while (fill_level < CAPACITY)
            random_request(92);
        repeat (100) random_request(40);

        start <= 1'b0;
        while (waiting_count != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);

        $display("Covered %0d requests: %0d inserts, %0d refused on a full store,",
                 requests_sent, inserted_count, refused_count);
        $display("  %0d range minimum answers and %0d flagged spans.",
                 answered_count, bad_range_count);
        if (error_count == 0 && waiting_count == 0)
            $display("tb_sequence_insert_range_min: clean");
        else
            $display("tb_sequence_insert_range_min: errors");
        $finish;
    end

endmodule
